### src/assert_macros.svh
// Assertion macros shared by the matcher modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/pdwm_pkg.sv
// Types and constants shared by the packed DNA window matcher modules.
package pdwm_pkg;

  localparam int unsigned BASES_PER_WORD = 16;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned OFFSET_W       = 4;
  localparam int unsigned COUNT_W        = 5;
  localparam int unsigned LEN_W          = 13;
  localparam int unsigned SIM_W          = 17;
  localparam int unsigned MAX_WINDOW_LEN = 4096;
  localparam int unsigned SIM_ONE        = 65536;
  localparam int unsigned DIFF_W         = 5;
  localparam int unsigned FIFO_DEPTH     = 2;
  localparam int unsigned FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned IN_DATA_W      = 160;
  localparam int unsigned OUT_DATA_W     = 16;
  localparam logic [WORD_W-1:0] LOW_BIT_MASK = 32'h5555_5555;

  // One input chunk as it arrives on the input channel.
  typedef struct packed {
    logic [WORD_W-1:0]   query_word_first;
    logic [WORD_W-1:0]   query_word_next;
    logic [OFFSET_W-1:0] query_offset;
    logic [WORD_W-1:0]   ref_word_first;
    logic [WORD_W-1:0]   ref_word_next;
    logic [OFFSET_W-1:0] ref_offset;
    logic [COUNT_W-1:0]  base_count;
    logic                ref_reverse;
    logic [LEN_W-1:0]    window_length;
    logic                first_chunk;
    logic                last_chunk;
  } pdwm_chunk_t;

  // A classified chunk: mismatch count plus what the back end needs to apply it.
  typedef struct packed {
    logic [DIFF_W-1:0] diffs;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  length;
    logic [LEN_W-1:0]  threshold;
  } pdwm_item_t;

endpackage

### src/pdwm_front.sv
// Front end: base extraction, reverse complement, mismatch count and threshold.
module pdwm_front (
  input  pdwm_pkg::pdwm_chunk_t       chunk,
  input  logic [pdwm_pkg::SIM_W-1:0]  similarity,
  output pdwm_pkg::pdwm_item_t        item
);
  import pdwm_pkg::*;

  logic [COUNT_W-1:0]  cnt_sat;
  logic [WORD_W-1:0]   tail_mask;
  logic [WORD_W-1:0]   q_bases;
  logic [WORD_W-1:0]   r_bases;
  logic [WORD_W-1:0]   r_revc;
  logic [WORD_W-1:0]   r_final;
  logic [WORD_W-1:0]   diff_bits;
  logic [SIM_W-1:0]    sim_sat;
  logic [LEN_W-1:0]    len_sat;
  logic [SIM_W+LEN_W:0] thr_sum;

  // Take 16 bases starting at the offset out of the two adjacent words.
  function automatic logic [WORD_W-1:0] pull(input logic [WORD_W-1:0] w0,
                                             input logic [WORD_W-1:0] w1,
                                             input logic [OFFSET_W-1:0] off);
    logic [2*WORD_W-1:0] both;
    both = {w0, w1} << {off, 1'b0};
    return both[2*WORD_W-1 -: WORD_W];
  endfunction

  // Reverse base order and complement every base.
  function automatic logic [WORD_W-1:0] rev_comp(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < BASES_PER_WORD; i++) begin
      r[2*i +: 2] = v[2*(BASES_PER_WORD-1-i) +: 2];
    end
    return ~r;
  endfunction

  function automatic logic [DIFF_W-1:0] count_ones(input logic [WORD_W-1:0] v);
    logic [DIFF_W-1:0] n;
    n = '0;
    for (int i = 0; i < BASES_PER_WORD; i++) begin
      n = n + DIFF_W'(v[2*i]);
    end
    return n;
  endfunction

  always_comb begin
    cnt_sat   = (chunk.base_count > COUNT_W'(BASES_PER_WORD)) ?
                COUNT_W'(BASES_PER_WORD) : chunk.base_count;
    // Top 2*count bits kept; a shift of the full width leaves all ones.
    tail_mask = ~({WORD_W{1'b1}} >> {cnt_sat, 1'b0});
    q_bases   = pull(chunk.query_word_first, chunk.query_word_next, chunk.query_offset)
                & tail_mask;
    r_bases   = pull(chunk.ref_word_first, chunk.ref_word_next, chunk.ref_offset)
                & tail_mask;
    r_revc    = rev_comp(r_bases) << {COUNT_W'(BASES_PER_WORD) - cnt_sat, 1'b0};
    r_final   = chunk.ref_reverse ? r_revc : r_bases;
    diff_bits = q_bases ^ r_final;
    diff_bits = (diff_bits | (diff_bits >> 1)) & LOW_BIT_MASK;

    sim_sat   = (similarity > SIM_W'(SIM_ONE)) ? SIM_W'(SIM_ONE) : similarity;
    len_sat   = (chunk.window_length > LEN_W'(MAX_WINDOW_LEN)) ?
                LEN_W'(MAX_WINDOW_LEN) : chunk.window_length;
    // Round half up: add one half in Q0.16 before dropping the fraction.
    thr_sum   = (SIM_W+LEN_W+1)'(sim_sat) * (SIM_W+LEN_W+1)'(len_sat)
                + (SIM_W+LEN_W+1)'(SIM_ONE / 2);

    item.diffs     = (cnt_sat == '0) ? '0 : count_ones(diff_bits);
    item.first     = chunk.first_chunk;
    item.last      = chunk.last_chunk;
    item.length    = len_sat;
    item.threshold = thr_sum[16 +: LEN_W];
  end

endmodule

### src/pdwm_fifo.sv
// Short queue of classified chunks between the front and back ends.
module pdwm_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pdwm_pkg::pdwm_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output pdwm_pkg::pdwm_item_t head_item
);
  import pdwm_pkg::*;
  `include "assert_macros.svh"

  pdwm_item_t            mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full       = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_ALWAYS(a_fifo_count_bound, clk, rst_n, count_r <= FIFO_CNT_W'(FIFO_DEPTH), "queue count above depth")
  `ASSERT_ALWAYS(a_fifo_ptr_gap, clk, rst_n, (count_r == '0 || count_r == FIFO_CNT_W'(FIFO_DEPTH)) == (wr_ptr_r == rd_ptr_r), "queue pointers disagree with count")

endmodule

### src/pdwm_back.sv
// Back end: running match count, threshold compare and the output register.
module pdwm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  pdwm_pkg::pdwm_item_t          head_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pdwm_pkg::LEN_W-1:0]    matched_bases,
  output logic                          accepted
);
  import pdwm_pkg::*;
  `include "assert_macros.svh"

  logic [LEN_W-1:0] running_r, running_nxt;
  logic [LEN_W-1:0] thresh_r, thresh_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0] matched_r, matched_nxt;
  logic             accepted_r, accepted_nxt;
  logic [LEN_W-1:0] base_count;
  logic [LEN_W-1:0] thr_use;
  logic             pass;

  // A non-final chunk never waits; a final one needs a free output slot.
  assign pop = head_valid && (!head_item.last || !out_valid_r || out_ready);

  always_comb begin
    base_count    = head_item.first ? head_item.length : running_r;
    thr_use       = head_item.first ? head_item.threshold : thresh_r;
    running_nxt   = running_r;
    thresh_nxt    = thresh_r;
    out_valid_nxt = out_valid_r && !out_ready;
    matched_nxt   = matched_r;
    accepted_nxt  = accepted_r;
    pass          = 1'b0;
    if (pop) begin
      running_nxt = (base_count > LEN_W'(head_item.diffs)) ?
                    base_count - LEN_W'(head_item.diffs) : '0;
      thresh_nxt  = thr_use;
      pass        = (running_nxt >= thr_use);
      if (head_item.last) begin
        out_valid_nxt = 1'b1;
        matched_nxt   = pass ? running_nxt : '0;
        accepted_nxt  = pass;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= '0;
      thresh_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      running_r   <= running_nxt;
      thresh_r    <= thresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    matched_r  <= matched_nxt;
    accepted_r <= accepted_nxt;
  end

  assign out_valid     = out_valid_r;
  assign matched_bases = matched_r;
  assign accepted      = accepted_r;

  `ASSERT_ALWAYS(a_back_count_range, clk, rst_n, running_r <= LEN_W'(MAX_WINDOW_LEN), "running count above window limit")
  `ASSERT_ALWAYS(a_back_reject_zero, clk, rst_n, out_valid_r |-> (accepted_r || matched_r == '0), "rejected window reports matches")
  `ASSERT_ALWAYS(a_back_no_rise, clk, rst_n, (pop && !head_item.first) |=> (running_r <= $past(running_r)), "running count rose without a new window")

endmodule

### src/packed_dna_window_matcher_core.sv
// A chunk word accepted on the input is written into the queue, and the back end applies it
// from the queue head when nothing waits ahead of it; a final chunk's result word is then
// registered in the output register that drives out_tdata.
// Throughput: one chunk word per cycle, set by the combinational front end and the count
// update in the back end; a stalled output holds a final chunk in the two-entry queue,
// and the input stalls once that queue is full.
// Reset: rst_n is synchronous and active low; it empties the queue, clears the running
// count and threshold to zero and sets similarity_q16 to 65536 (exact match required).
module packed_dna_window_matcher_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input chunk channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0 up: query_word_first[31:0], query_word_next[63:32],
  // query_offset[67:64], ref_word_first[99:68], ref_word_next[131:100],
  // ref_offset[135:132], base_count[140:136], ref_reverse[141],
  // window_length[154:142], zero padding[159:155].
  input  logic [pdwm_pkg::IN_DATA_W-1:0]    in_tdata,
  // Fields from bit 0 up: first_chunk[0].
  input  logic                              in_tuser,
  // last_chunk.
  input  logic                              in_tlast,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0 up: matched_bases[12:0], accepted[13], zero padding[15:14].
  output logic [pdwm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Configuration port; one register, similarity_q16, at byte address 0.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [1:0]                        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import pdwm_pkg::*;

  logic [SIM_W-1:0] similarity_r, similarity_nxt;
  logic             cfg_write;
  pdwm_chunk_t      chunk;
  pdwm_item_t       front_item;
  pdwm_item_t       head_item;
  logic             fifo_full;
  logic             head_valid;
  logic             pop;
  logic             in_accept;
  logic [LEN_W-1:0] matched_bases;
  logic             accepted;

  // The register file holds one register, so every address selects it; the address
  // bits are only the byte lanes of that word.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = {(32-SIM_W)'(0), similarity_r}
                      | {30'd0, cfg_paddr & 2'b00};

  always_comb begin
    similarity_nxt = similarity_r;
    if (cfg_write) begin
      similarity_nxt = cfg_pwdata[SIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      similarity_r <= SIM_W'(SIM_ONE);
    end else begin
      similarity_r <= similarity_nxt;
    end
  end

  // Unpack the chunk word into its fields.
  always_comb begin
    chunk.query_word_first = in_tdata[31:0];
    chunk.query_word_next  = in_tdata[63:32];
    chunk.query_offset     = in_tdata[67:64];
    chunk.ref_word_first   = in_tdata[99:68];
    chunk.ref_word_next    = in_tdata[131:100];
    chunk.ref_offset       = in_tdata[135:132];
    chunk.base_count       = in_tdata[140:136];
    chunk.ref_reverse      = in_tdata[141];
    chunk.window_length    = in_tdata[154:142];
    chunk.first_chunk      = in_tuser;
    chunk.last_chunk       = in_tlast;
  end

  // The front end works in the cycle of acceptance; its result waits in the queue
  // until the back end takes it, so an output stall never blocks the input directly.
  assign in_tready = !fifo_full;
  assign in_accept = in_tvalid && in_tready;

  pdwm_front u_front (
    .chunk      (chunk),
    .similarity (similarity_r),
    .item       (front_item)
  );

  pdwm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_accept),
    .push_item  (front_item),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // The back end applies mismatch counts in order and holds each result word in
  // its output register until the consumer takes it.
  pdwm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .matched_bases (matched_bases),
    .accepted      (accepted)
  );

  assign out_tdata = {(OUT_DATA_W-LEN_W-1)'(0), accepted, matched_bases};

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the packed DNA window matcher core.
module tb;
  import pdwm_pkg::*;

  // Byte address of the similarity register on the configuration port.
  localparam logic [1:0] SIMILARITY_ADDR = 2'd0;

  // One expected result word: the surviving match count and the verdict.
  typedef struct packed {
    logic [LEN_W-1:0] matched;
    logic             accepted;
  } window_score_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // All block inputs start at known values.
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [1:0]            cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  // Chunks waiting to go out on the input channel, and the scores that the
  // accepted final chunks are still owed.
  pdwm_chunk_t   chunk_q[$];
  window_score_t expected_scores[$];

  // Our own copy of the block's state and configuration.
  logic [SIM_W-1:0] similarity_model = SIM_W'(SIM_ONE);
  logic [LEN_W-1:0] running_matches = '0;
  logic [LEN_W-1:0] pass_threshold = '0;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;

  packed_dna_window_matcher_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Base arithmetic used both by the predictor and by the stimulus builder.
  // ---------------------------------------------------------------------

  // Pulls n bases starting at base position off of w0, spilling into w1,
  // first base in the top bits and the unused tail cleared.
  function automatic logic [31:0] extract_bases(logic [31:0] w0, logic [31:0] w1,
                                                int off, int n);
    logic [31:0] r;
    int sh;
    r = w0 << (2 * off);
    if (BASES_PER_WORD - off < n) r = r | (w1 >> (2 * (BASES_PER_WORD - off)));
    if (n < BASES_PER_WORD) begin
      sh = 2 * (BASES_PER_WORD - n);
      r = (r >> sh) << sh;
    end
    return r;
  endfunction

  // Reverses the order of the sixteen bases and complements each one.
  function automatic logic [31:0] reverse_complement(logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 16; i++) r[2*i +: 2] = ~v[30-2*i +: 2];
    return r;
  endfunction

  // Number of base positions where the two packed words differ.
  function automatic int unsigned differing_bases(logic [31:0] a, logic [31:0] b);
    logic [31:0] x;
    x = a ^ b;
    x = (x | (x >> 1)) & LOW_BIT_MASK;
    return $countones(x);
  endfunction

  // ---------------------------------------------------------------------
  // Predictor: applies one accepted chunk to the model state and queues the
  // score that a final chunk produces.
  // ---------------------------------------------------------------------
  task automatic score_chunk(input pdwm_chunk_t c);
    logic [SIM_W-1:0] sim;
    logic [LEN_W-1:0] len;
    logic [31:0]      prod;
    logic [31:0]      qw;
    logic [31:0]      rw;
    int               cs;
    int unsigned      d;
    window_score_t    s;
    // A new window loads the full length as the count and fixes the threshold
    // from the similarity, both saturated first.
    if (c.first_chunk) begin
      sim  = (similarity_model > SIM_ONE) ? SIM_W'(SIM_ONE) : similarity_model;
      len  = (c.window_length > MAX_WINDOW_LEN) ? LEN_W'(MAX_WINDOW_LEN) : c.window_length;
      prod = 32'(sim) * 32'(len) + 32'd32768;
      running_matches = len;
      pass_threshold  = LEN_W'(prod >> 16);
    end
    // Oversized chunks are clipped to one word; an empty chunk compares nothing.
    cs = (c.base_count > BASES_PER_WORD) ? BASES_PER_WORD : int'(c.base_count);
    if (cs != 0) begin
      qw = extract_bases(c.query_word_first, c.query_word_next, c.query_offset, cs);
      rw = extract_bases(c.ref_word_first, c.ref_word_next, c.ref_offset, cs);
      if (c.ref_reverse) rw = reverse_complement(rw) << (2 * (BASES_PER_WORD - cs));
      d = differing_bases(qw, rw);
      // The count never goes below zero.
      running_matches = (running_matches > d) ? running_matches - LEN_W'(d) : '0;
    end
    if (c.last_chunk) begin
      s.accepted = (running_matches >= pass_threshold);
      s.matched  = s.accepted ? running_matches : '0;
      expected_scores.insert(expected_scores.size(), s);
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------

  // Appends one chunk to the end of the pending queue.
  function automatic void enqueue_chunk(pdwm_chunk_t c);
    chunk_q.insert(chunk_q.size(), c);
  endfunction

  // Builds a chunk whose reference side matches the query side except for
  // mut deliberately altered bases. Offsets of -1 are picked at random.
  function automatic pdwm_chunk_t make_chunk(bit is_first, bit is_last, int cnt, int wlen,
                                             bit rev, int mut, int qo, int ro);
    pdwm_chunk_t c;
    logic [31:0] pat;
    logic [31:0] qw;
    logic [63:0] span;
    int          cs;
    c.query_word_first = $urandom;
    c.query_word_next  = $urandom;
    c.query_offset     = (qo < 0) ? OFFSET_W'($urandom_range(15)) : OFFSET_W'(qo);
    c.ref_offset       = (ro < 0) ? OFFSET_W'($urandom_range(15)) : OFFSET_W'(ro);
    c.base_count       = COUNT_W'(cnt);
    c.ref_reverse      = rev;
    c.window_length    = LEN_W'(wlen);
    c.first_chunk      = is_first;
    c.last_chunk       = is_last;
    cs = (cnt == 0 || cnt > BASES_PER_WORD) ? BASES_PER_WORD : cnt;
    if (rev) begin
      // Store the reverse complement of the query so that flipping it back
      // lines up base for base; bases past the chunk are random filler.
      qw  = extract_bases(c.query_word_first, c.query_word_next, c.query_offset, cs);
      pat = (reverse_complement(qw) << (2 * (BASES_PER_WORD - cs)))
          | ($urandom & ~(32'hFFFF_FFFF << (2 * (BASES_PER_WORD - cs))));
    end else begin
      pat = extract_bases(c.query_word_first, c.query_word_next, c.query_offset,
                          BASES_PER_WORD);
    end
    for (int k = 0; k < mut; k++)
      pat = pat ^ (32'($urandom_range(1, 3)) << (2 * $urandom_range(15)));
    // Drop the pattern into two random words at the reference offset.
    span = {$urandom, $urandom};
    span[63 - 2 * int'(c.ref_offset) -: 32] = pat;
    c.ref_word_first = span[63:32];
    c.ref_word_next  = span[31:0];
    return c;
  endfunction

  // Queues one window of one to six chunks and returns how many were queued.
  // A broken window loses its opening or its closing marker.
  function automatic int push_window(bit drop_first, bit drop_last);
    int n;
    int cnts[6];
    int total;
    int len;
    int pick;
    bit rev;
    n     = $urandom_range(1, 6);
    rev   = ($urandom_range(9) < 3);
    total = 0;
    for (int i = 0; i < n; i++) begin
      cnts[i] = ($urandom_range(3) == 0) ? BASES_PER_WORD : $urandom_range(1, 16);
      total += cnts[i];
    end
    pick = $urandom_range(9);
    if (pick < 7) len = total;
    else if (pick < 9) len = $urandom_range(1, MAX_WINDOW_LEN);
    else len = $urandom_range(0, 8191);
    for (int i = 0; i < n; i++) begin
      // Only the opening chunk's length counts; the rest carry junk there.
      enqueue_chunk(make_chunk(i == 0 && !drop_first, i == n - 1 && !drop_last,
                               cnts[i], (i == 0) ? len : $urandom_range(0, 8191),
                               rev, $urandom_range(1) ? 0 : $urandom_range(1, 3),
                               -1, -1));
    end
    return n;
  endfunction

  // Mostly well-formed windows with random content, plus free-standing noise
  // chunks and windows with a missing marker.
  task automatic add_random_chunks(input int target);
    int added;
    int kind;
    pdwm_chunk_t c;
    added = 0;
    while (added < target) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        added += push_window(1'b0, 1'b0);
      end else if (kind < 85) begin
        c = make_chunk($urandom_range(9) < 3, $urandom_range(9) < 3, $urandom_range(0, 31),
                       $urandom_range(0, 8191), $urandom_range(1), $urandom_range(0, 16),
                       -1, -1);
        c.ref_word_first = $urandom;
        c.ref_word_next  = $urandom;
        enqueue_chunk(c);
        added++;
      end else begin
        kind = $urandom_range(1);
        added += push_window(kind == 0, kind == 1);
      end
    end
  endtask

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: %s mismatch: expected %0d, got %0d", what, want, got);
  endtask

  // ---------------------------------------------------------------------
  // Configuration port access. Only used while the block is idle.
  // ---------------------------------------------------------------------
  task automatic cfg_write_similarity(input logic [SIM_W-1:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SIMILARITY_ADDR;
    cfg_pwdata  <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    // The register takes the value at the next edge, which ends the access.
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    similarity_model = v;
  endtask

  // Reads the similarity register back and compares it with our copy.
  task automatic cfg_check_similarity();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= SIMILARITY_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    // Read data is stable in the middle of the access cycle.
    @(negedge clk);
    if (cfg_prdata != 32'(similarity_model))
      note_mismatch("similarity register read", similarity_model, cfg_prdata);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Waits until every queued chunk has been taken and every score has come
  // back, then waits on so that chunks without a score have left the
  // pipeline too. Checked at the falling edge, away from any update.
  task automatic wait_drained();
    do @(negedge clk);
    while (chunk_q.size() != 0 || in_tvalid || expected_scores.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: offers the next chunk once the previous word has been taken,
  // idling at random at the current rate.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : chunk_driver
    pdwm_chunk_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (chunk_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = chunk_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {5'b0, c.window_length, c.ref_reverse, c.base_count, c.ref_offset,
                      c.ref_word_next, c.ref_word_first, c.query_offset,
                      c.query_word_next, c.query_word_first};
        in_tuser  <= c.first_chunk;
        in_tlast  <= c.last_chunk;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // The result side stalls at random at the current rate.
  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------------
  // Monitor: predicts from every accepted input word and checks every
  // accepted result word against the oldest waiting score.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : score_monitor
    pdwm_chunk_t   c;
    window_score_t s;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        c.query_word_first = in_tdata[31:0];
        c.query_word_next  = in_tdata[63:32];
        c.query_offset     = in_tdata[67:64];
        c.ref_word_first   = in_tdata[99:68];
        c.ref_word_next    = in_tdata[131:100];
        c.ref_offset       = in_tdata[135:132];
        c.base_count       = in_tdata[140:136];
        c.ref_reverse      = in_tdata[141];
        c.window_length    = in_tdata[154:142];
        c.first_chunk      = in_tuser;
        c.last_chunk       = in_tlast;
        score_chunk(c);
      end
      if (out_tvalid && out_tready) begin
        if (expected_scores.size() == 0) begin
          note_mismatch("unexpected result word", 0, out_tdata);
        end else begin
          s = expected_scores.pop_front();
          if (out_tdata[12:0] != s.matched)
            note_mismatch("matched_bases", s.matched, out_tdata[12:0]);
          if (out_tdata[13] != s.accepted)
            note_mismatch("accepted", s.accepted, out_tdata[13]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin : test_sequence
    pdwm_chunk_t c;
    logic [SIM_W-1:0] sim_setting;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Similarity must come out of reset at exactly one.
    cfg_check_similarity();

    // Directed chunks, all at the reset similarity of one.
    // A final chunk with no opening chunk works on the cleared state.
    enqueue_chunk(make_chunk(1'b0, 1'b1, 16, 0, 1'b0, 0, -1, -1));
    // All-ones words on both sides: a full match.
    c = make_chunk(1'b1, 1'b1, 16, 16, 1'b0, 0, 0, 0);
    c.query_word_first = '1; c.query_word_next = '1;
    c.ref_word_first   = '1; c.ref_word_next   = '1;
    enqueue_chunk(c);
    // All-zeros query against all-ones reference: every base differs.
    c.query_word_first = '0; c.query_word_next = '0;
    enqueue_chunk(c);
    // Two chunks whose query side starts at the last base of a word; the first one's reference side does too.
    enqueue_chunk(make_chunk(1'b1, 1'b0, 16, 32, 1'b0, 0, 15, 15));
    enqueue_chunk(make_chunk(1'b0, 1'b1, 16, 0, 1'b0, 0, 15, 0));
    // Reverse-complemented reference that matches exactly.
    enqueue_chunk(make_chunk(1'b1, 1'b1, 16, 16, 1'b1, 0, -1, -1));
    // Empty chunk: nothing is compared, the window length survives.
    enqueue_chunk(make_chunk(1'b1, 1'b1, 0, 5, 1'b0, 2, -1, -1));
    // Oversized base count is clipped to one word.
    enqueue_chunk(make_chunk(1'b1, 1'b1, 31, 16, 1'b0, 0, -1, -1));
    // Zero window length gives a zero count and a zero threshold.
    enqueue_chunk(make_chunk(1'b1, 1'b1, 4, 0, 1'b0, 0, -1, -1));
    // Oversized window length is clipped; one bad base fails the threshold.
    enqueue_chunk(make_chunk(1'b1, 1'b1, 16, 8191, 1'b0, 1, -1, -1));
    // Longest legal window over three chunks, with a plain middle chunk.
    enqueue_chunk(make_chunk(1'b1, 1'b0, 16, MAX_WINDOW_LEN, 1'b0, 0, -1, -1));
    enqueue_chunk(make_chunk(1'b0, 1'b0, 7, 0, 1'b1, 0, -1, -1));
    enqueue_chunk(make_chunk(1'b0, 1'b1, 1, 0, 1'b0, 0, -1, -1));
    // More differences than the window is long: the count stops at zero.
    c = make_chunk(1'b1, 1'b1, 16, 3, 1'b0, 0, 0, 0);
    c.query_word_first = '0; c.query_word_next = '0;
    c.ref_word_first   = '1; c.ref_word_next   = '1;
    enqueue_chunk(c);
    // Single-base chunks at the far end of a word, both orientations.
    enqueue_chunk(make_chunk(1'b1, 1'b1, 1, 1, 1'b0, 0, 15, 15));
    enqueue_chunk(make_chunk(1'b1, 1'b1, 1, 1, 1'b1, 0, 0, 15));
    wait_drained();

    // Random phases. Each one after the first changes the similarity while idle,
    // runs under its own idling pattern, and halfway through holds the sender until
    // every score so far has come back.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  sim_setting = SIM_W'(SIM_ONE); end
        1: begin send_idle_pct = 63; stall_pct = 0;  sim_setting = '0;              end
        2: begin send_idle_pct = 0;  stall_pct = 63; sim_setting = '1;              end
        3: begin send_idle_pct = 30; stall_pct = 30; sim_setting = 17'd58982;      end
        default: begin
          send_idle_pct = 30; stall_pct = 30;
          sim_setting = SIM_W'($urandom_range(45000, SIM_ONE - 1));
        end
      endcase
      // The first phase keeps the reset value; the rest write and read back.
      if (ph != 0) begin
        cfg_write_similarity(sim_setting);
        cfg_check_similarity();
        @(negedge clk);
      end
      add_random_chunks(64);
      wait_drained();
      add_random_chunks(64);
      wait_drained();
    end

    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
